### rtl/shrr_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 reduced-round unit package
// Shared payload types, controller commands, and the round constant table.
// ----------------------------------------------------------------------------
package shrr_pkg;

   localparam int unsigned WordWidth = 32;

   typedef struct packed {
      logic [31:0] message_word;
      logic [5:0]  valid_bits;
      logic        final_item;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        status;
      logic        last_result;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      WSEL_DATA = 3'b000,
      WSEL_PAD  = 3'b001,
      WSEL_ZERO = 3'b010,
      WSEL_LENH = 3'b011,
      WSEL_LENL = 3'b100
   } wsel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_iv;
      logic       clear_len;
      logic       add_len;
      logic       push;
      wsel_type   wsel;
      logic       start_block;
      logic       round_step;
      logic       finish_block;
      logic [2:0] out_index;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       block_full;
      logic [3:0] fill;
      logic       last_round;
   } dp_stat_type;

   localparam int unsigned RoundCodeW = 7;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam int unsigned CsrRoundCount = 0;
   localparam int unsigned CsrIv01       = 1;
   localparam int unsigned CsrIv23       = 2;
   localparam int unsigned CsrIv45       = 3;
   localparam int unsigned CsrIv67       = 4;

endpackage

### rtl/sha256_hash_reduced_rounds_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 reduced-round hash unit
// Words are taken only in the idle state; intake stalls during padding, rounds and output.
// The final item is padded by the unit, which then returns eight digest responses, one
// a cycle unless rsp_stall holds them, or one error response for a bad partial byte.
// Reset is synchronous; it restores the standard IV and 64 rounds.
// ----------------------------------------------------------------------------
module sha256_hash_reduced_rounds_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  shrr_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output shrr_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_write,
   input  logic [2:0]                 csr_index,
   input  logic [63:0]                csr_data
);

   logic [6:0]   round_ff;
   logic [255:0] iv_ff;
   logic [5:0]   data_bits;
   logic         rsp_error;
   logic [2:0]   rsp_index;
   logic [31:0]  digest_word;
   shrr_pkg::dp_cmd_type  cmd;
   shrr_pkg::dp_stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= 7'd64;
         iv_ff    <= {64'h6a09e667bb67ae85, 64'h3c6ef372a54ff53a,
                      64'h510e527f9b05688c, 64'h1f83d9ab5be0cd19};
      end else if (csr_write) begin
         case (csr_index)
            3'(shrr_pkg::CsrRoundCount): round_ff <= csr_data[6:0];
            3'(shrr_pkg::CsrIv01):       iv_ff[255:192] <= csr_data;
            3'(shrr_pkg::CsrIv23):       iv_ff[191:128] <= csr_data;
            3'(shrr_pkg::CsrIv45):       iv_ff[127:64]  <= csr_data;
            3'(shrr_pkg::CsrIv67):       iv_ff[63:0]    <= csr_data;
            default: ;
         endcase
      end
   end

   shrr_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_error   (rsp_error),
      .rsp_index   (rsp_index),
      .cmd         (cmd),
      .stat        (stat),
      .data_bits   (data_bits)
   );

   shrr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .data_word   (req_payload.message_word),
      .data_bits   (data_bits),
      .round_count (round_ff),
      .iv_value    (iv_ff),
      .digest_word (digest_word)
   );

   assign rsp_payload.digest_word = rsp_error ? 32'd0 : digest_word;
   assign rsp_payload.word_index  = rsp_index;
   assign rsp_payload.status      = rsp_error;
   assign rsp_payload.last_result = rsp_error || (rsp_index == 3'd7);

endmodule

### rtl/shrr_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 reduced-round datapath
// Message window, bit length, schedule expansion, round logic and chaining.
// ----------------------------------------------------------------------------
module shrr_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  shrr_pkg::dp_cmd_type       cmd,
   output shrr_pkg::dp_stat_type      stat,
   input  logic [31:0]                data_word,
   input  logic [5:0]                 data_bits,
   input  logic [6:0]                 round_count,
   input  logic [255:0]               iv_value,
   output logic [31:0]                digest_word
);

   logic [31:0] window_ff [16];
   logic [31:0] window_in [16];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] work_ff [8];
   logic [31:0] work_in [8];
   logic [4:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [6:0]  round_ff, round_in;
   logic [6:0]  limit;
   logic [31:0] push_word;
   logic [31:0] mask;
   logic [31:0] s0, s1, w_new, wt;
   logic [31:0] t1, t2, ch, mj, e, a;

   assign limit = (round_count > 7'd64) ? 7'd64 : round_count;
   assign mask  = (data_bits == 6'd0) ? 32'd0 : (32'hFFFFFFFF << (6'd32 - data_bits));

   always_comb begin
      unique case (cmd.wsel)
         shrr_pkg::WSEL_DATA: push_word = data_word;
         shrr_pkg::WSEL_PAD:  push_word = (data_word & mask) | (32'h80000000 >> data_bits);
         shrr_pkg::WSEL_ZERO: push_word = 32'd0;
         shrr_pkg::WSEL_LENH: push_word = len_ff[63:32];
         shrr_pkg::WSEL_LENL: push_word = len_ff[31:0];
         default:             push_word = 32'd0;
      endcase
   end

   always_comb begin
      s0 = {window_ff[1][6:0], window_ff[1][31:7]} ^
           {window_ff[1][17:0], window_ff[1][31:18]} ^ (window_ff[1] >> 3);
      s1 = {window_ff[14][16:0], window_ff[14][31:17]} ^
           {window_ff[14][18:0], window_ff[14][31:19]} ^ (window_ff[14] >> 10);
      w_new = s1 + window_ff[9] + s0 + window_ff[0];
      wt = window_ff[0];
      e = work_ff[4];
      a = work_ff[0];
      ch = (e & work_ff[5]) ^ (~e & work_ff[6]);
      mj = (a & work_ff[1]) ^ (a & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
      t1 = work_ff[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
           + ch + shrr_pkg::ROUND_K[round_ff[5:0]] + wt;
      t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]}) + mj;
   end

   always_comb begin
      window_in = window_ff;
      chain_in  = chain_ff;
      work_in   = work_ff;
      fill_in   = fill_ff;
      len_in    = len_ff;
      round_in  = round_ff;
      if (cmd.clear_len) begin
         len_in  = 64'd0;
         fill_in = 5'd0;
      end
      if (cmd.add_len) begin
         len_in = len_ff + {58'd0, data_bits};
      end
      if (cmd.load_iv) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = iv_value[255 - 32 * i -: 32];
         end
      end
      if (cmd.push) begin
         window_in[fill_ff[3:0]] = push_word;
         fill_in = fill_ff + 5'd1;
      end
      if (cmd.start_block) begin
         work_in  = chain_ff;
         round_in = 7'd0;
         fill_in  = 5'd0;
      end
      if (cmd.round_step) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
         for (int i = 0; i < 15; i++) begin
            window_in[i] = window_ff[i + 1];
         end
         window_in[15] = w_new;
         round_in = round_ff + 7'd1;
      end
      if (cmd.finish_block) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      chain_ff  <= chain_in;
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            work_ff[i] <= 32'd0;
         end
         fill_ff  <= 5'd0;
         len_ff   <= 64'd0;
         round_ff <= 7'd0;
      end else begin
         work_ff  <= work_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         round_ff <= round_in;
      end
   end

   assign stat.block_full = fill_ff[4];
   assign stat.fill       = fill_ff[3:0];
   assign stat.last_round = (round_ff >= limit);
   assign digest_word     = chain_ff[cmd.out_index];

endmodule

### rtl/shrr_control.sv
// ----------------------------------------------------------------------------
// SHA-256 reduced-round controller
// Sequences word intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module shrr_control (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  shrr_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_error,
   output logic [2:0]                 rsp_index,
   output shrr_pkg::dp_cmd_type       cmd,
   input  shrr_pkg::dp_stat_type      stat,
   output logic [5:0]                 data_bits
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_TAIL   = 7'b0000010,
      ST_ZEROS  = 7'b0000100,
      ST_LENGTH = 7'b0001000,
      ST_ROUNDS = 7'b0010000,
      ST_FOLD   = 7'b0100000,
      ST_OUTPUT = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic        active_ff, active_in;
   logic        final_ff, final_in;
   logic        full32_ff, full32_in;
   logic        lenlo_ff, lenlo_in;
   logic        err_ff, err_in;
   logic [2:0]  idx_ff, idx_in;
   logic [5:0]  vb;
   logic [7:0]  pbyte;
   logic        bad;
   logic        accept;

   assign vb    = (req_payload.valid_bits > 6'd32) ? 6'd32 : req_payload.valid_bits;
   assign pbyte = 8'(req_payload.message_word >> (5'd24 - {vb[4:3], 3'd0}));
   assign bad   = (vb[2:0] != 3'd0) && ((pbyte & (8'hFF >> vb[2:0])) != 8'd0);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign data_bits = final_ff ? 6'd0 : (req_payload.final_item ? vb : 6'd32);
   assign rsp_valid = (state_ff == ST_OUTPUT);
   assign rsp_error = err_ff;
   assign rsp_index = idx_ff;

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      final_in  = final_ff;
      full32_in = full32_ff;
      lenlo_in  = lenlo_ff;
      err_in    = err_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      cmd.wsel  = shrr_pkg::WSEL_DATA;
      cmd.out_index = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_iv = !active_ff;
               cmd.clear_len = !active_ff;
               active_in = 1'b1;
               if (!req_payload.final_item) begin
                  cmd.add_len = 1'b1;
                  cmd.push = 1'b1;
                  if (stat.fill == 4'd15) begin
                     final_in = 1'b0;
                     state_in = ST_ROUNDS;
                     cmd.start_block = 1'b1;
                  end
               end else if (bad) begin
                  err_in = 1'b1;
                  idx_in = 3'd0;
                  active_in = 1'b0;
                  state_in = ST_OUTPUT;
               end else begin
                  cmd.add_len = 1'b1;
                  cmd.push = 1'b1;
                  cmd.wsel = (vb == 6'd32) ? shrr_pkg::WSEL_DATA : shrr_pkg::WSEL_PAD;
                  full32_in = (vb == 6'd32);
                  final_in = 1'b1;
                  lenlo_in = 1'b0;
                  err_in = 1'b0;
                  if (stat.fill == 4'd15) begin
                     state_in = ST_ROUNDS;
                     cmd.start_block = 1'b1;
                  end else begin
                     state_in = full32_in ? ST_TAIL : ST_ZEROS;
                  end
               end
            end
         end
         ST_TAIL: begin
            cmd.push = 1'b1;
            cmd.wsel = shrr_pkg::WSEL_PAD;
            full32_in = 1'b0;
            if (stat.fill == 4'd15) begin
               state_in = ST_ROUNDS;
               cmd.start_block = 1'b1;
            end else begin
               state_in = ST_ZEROS;
            end
         end
         ST_ZEROS: begin
            if (stat.fill == 4'd14) begin
               state_in = ST_LENGTH;
            end else begin
               cmd.push = 1'b1;
               cmd.wsel = shrr_pkg::WSEL_ZERO;
               if (stat.fill == 4'd15) begin
                  state_in = ST_ROUNDS;
                  cmd.start_block = 1'b1;
               end
            end
         end
         ST_LENGTH: begin
            cmd.push = 1'b1;
            cmd.wsel = lenlo_ff ? shrr_pkg::WSEL_LENL : shrr_pkg::WSEL_LENH;
            if (lenlo_ff) begin
               state_in = ST_ROUNDS;
               cmd.start_block = 1'b1;
            end
            lenlo_in = 1'b1;
         end
         ST_ROUNDS: begin
            if (stat.last_round) begin
               state_in = ST_FOLD;
            end else begin
               cmd.round_step = 1'b1;
            end
         end
         ST_FOLD: begin
            cmd.finish_block = 1'b1;
            idx_in = 3'd0;
            if (!final_ff) begin
               state_in = ST_IDLE;
            end else if (full32_ff) begin
               state_in = ST_TAIL;
            end else if (lenlo_ff) begin
               state_in = ST_OUTPUT;
            end else begin
               state_in = ST_ZEROS;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (err_ff || idx_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  active_in = 1'b0;
                  final_in = 1'b0;
                  err_in = 1'b0;
                  cmd.clear_len = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= 1'b0;
         final_ff  <= 1'b0;
         full32_ff <= 1'b0;
         lenlo_ff  <= 1'b0;
         err_ff    <= 1'b0;
         idx_ff    <= 3'd0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         final_ff  <= final_in;
         full32_ff <= full32_in;
         lenlo_ff  <= lenlo_in;
         err_ff    <= err_in;
         idx_ff    <= idx_in;
      end
   end

endmodule

### tb/tb_sha256_hash_reduced_rounds_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 reduced-round hash unit testbench
// Sends message words with random gaps and digest backpressure, predicts each
// digest or error response, and compares every response field by field.
// A directed table covers the corner cases, then random messages follow.
// ----------------------------------------------------------------------------
module tb_sha256_hash_reduced_rounds_unit;

   localparam int unsigned CycleLimit = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   shrr_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   shrr_pkg::rsp_payload_type rsp_payload;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   sha256_hash_reduced_rounds_unit dut (.*);

   always #10 clock = ~clock;

   // Predictor state.
   logic [6:0] round_cfg;
   logic [63:0] iv_cfg [4];
   logic [31:0] chain [8];
   logic [31:0] block_words [16];
   int unsigned fill_count;
   logic [63:0] msg_bits;
   bit in_message;

   shrr_pkg::rsp_payload_type digest_queue [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_count = 0;
   bit rsp_gaps_on = 1'b1;
   bit table_mode = 1'b1;

   typedef struct {
      logic [31:0] word;
      logic [5:0] vbits;
      logic fin;
      bit has_fixed;
      shrr_pkg::rsp_payload_type fixed_rsp;
   } stim_row_type;

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void compress_block();
      logic [31:0] sched [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2, ch, mj;
      int unsigned rounds;
      rounds = (round_cfg > 64) ? 64 : round_cfg;
      for (int t = 0; t < 16; t++) sched[t] = block_words[t];
      for (int t = 16; t < 64; t++) begin
         s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
         s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < rounds; t++) begin
         ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
         mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch
              + shrr_pkg::ROUND_K[t] + sched[t];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + mj;
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
   endfunction

   function automatic void add_block_word(logic [31:0] w);
      block_words[fill_count] = w;
      fill_count++;
      if (fill_count == 16) begin
         compress_block();
         fill_count = 0;
      end
   endfunction

   function automatic void end_message();
      fill_count = 0;
      msg_bits = '0;
      in_message = 1'b0;
   endfunction

   function automatic void hash_word(shrr_pkg::req_payload_type r);
      int unsigned vb, part;
      logic [7:0] tail;
      logic [31:0] mask;
      shrr_pkg::rsp_payload_type p;
      if (!in_message) begin
         for (int i = 0; i < 4; i++) begin
            chain[2*i] = iv_cfg[i][63:32];
            chain[2*i+1] = iv_cfg[i][31:0];
         end
         in_message = 1'b1;
      end
      if (!r.final_item) begin
         msg_bits += 32;
         add_block_word(r.message_word);
         return;
      end
      vb = (r.valid_bits > 32) ? 32 : r.valid_bits;
      part = vb % 8;
      if (part != 0) begin
         tail = 8'(r.message_word >> (24 - 8 * (vb / 8)));
         if ((tail & (8'hff >> part)) != 0) begin
            p = '0;
            p.status = 1'b1;
            p.last_result = 1'b1;
            digest_queue.push_back(p);
            end_message();
            return;
         end
      end
      msg_bits += vb;
      if (vb == 32) begin
         add_block_word(r.message_word);
         add_block_word(32'h8000_0000);
      end else begin
         mask = (vb == 0) ? 32'h0 : (32'hffff_ffff << (32 - vb));
         add_block_word((r.message_word & mask) | (32'h8000_0000 >> vb));
      end
      while (fill_count != 14) add_block_word(32'h0);
      add_block_word(msg_bits[63:32]);
      add_block_word(msg_bits[31:0]);
      for (int i = 0; i < 8; i++) begin
         p.digest_word = chain[i];
         p.word_index = 3'(i);
         p.status = 1'b0;
         p.last_result = (i == 7);
         digest_queue.push_back(p);
      end
      end_message();
   endfunction

   task automatic write_csr(int unsigned idx, logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= 3'(idx);
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == shrr_pkg::CsrRoundCount) round_cfg = value[6:0];
      else iv_cfg[idx - 1] = value;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_word(logic [31:0] w, logic [5:0] vb, logic fin);
      int unsigned gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{message_word: w, valid_bits: vb, final_item: fin};
      do @(posedge clock); while (req_stall);
   endtask

   // Sends a random message of n words; broken ones leave random pad bits in the tail.
   task automatic send_message(int unsigned n, bit broken);
      logic [5:0] vb;
      logic [31:0] w;
      for (int i = 0; i < n - 1; i++) send_word($urandom, 6'($urandom), 1'b0);
      vb = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
      w = $urandom;
      if (!broken && vb < 32) begin
         w = (vb == 0) ? $urandom & 32'h0 : w & ~(32'hffff_ffff >> vb);
         if ($urandom_range(0, 1)) w = w | ($urandom & (32'hffff_ffff >> ((vb + 7) / 8 * 8)));
      end
      send_word(w, vb, 1'b1);
   endtask

   // Response checking with random backpressure.
   always @(posedge clock) begin
      shrr_pkg::rsp_payload_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_queue.size() == 0) begin
            $error("unexpected response %h", rsp_payload);
            error_count++;
         end else begin
            want = digest_queue.pop_front();
            if (rsp_payload.digest_word !== want.digest_word) begin
               $error("digest_word expected %h actual %h", want.digest_word,
                      rsp_payload.digest_word);
               error_count++;
            end
            if (rsp_payload.word_index !== want.word_index) begin
               $error("word_index expected %0d actual %0d", want.word_index,
                      rsp_payload.word_index);
               error_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.last_result !== want.last_result) begin
               $error("last_result expected %0d actual %0d", want.last_result,
                      rsp_payload.last_result);
               error_count++;
            end
         end
      end
      if (hold_count != 0) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count - 1;
      end else if (rsp_gaps_on && $urandom_range(0, 49) == 0) begin
         rsp_stall <= 1'b1;
         hold_count <= $urandom_range(10, 40);
      end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (cycle_count == CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   stim_row_type directed [] = '{
      // Empty message with the standard IV and 64 rounds.
      '{32'h0, 6'd0, 1'b1, 1'b1, '{32'he3b0c442, 3'd0, 1'b0, 1'b0}},
      // Unused bits set in the partial byte.
      '{32'h4000_0000, 6'd1, 1'b1, 1'b1, '{32'h0, 3'd0, 1'b1, 1'b1}},
      '{32'hff40_0000, 6'd9, 1'b1, 1'b1, '{32'h0, 3'd0, 1'b1, 1'b1}},
      '{32'hffff_ffff, 6'd31, 1'b1, 1'b1, '{32'h0, 3'd0, 1'b1, 1'b1}},
      '{32'h6162_6300, 6'd24, 1'b1, 1'b1, '{32'hba7816bf, 3'd0, 1'b0, 1'b0}},
      '{32'hffff_ffff, 6'd32, 1'b1, 1'b0, '{default: '0}},
      '{32'hffff_ffff, 6'd63, 1'b1, 1'b0, '{default: '0}},
      '{32'hffff_ffff, 6'd40, 1'b0, 1'b0, '{default: '0}},
      '{32'h8000_0000, 6'd1, 1'b1, 1'b0, '{default: '0}},
      '{32'hfe00_0000, 6'd7, 1'b1, 1'b0, '{default: '0}},
      '{32'h1234_5678, 6'd0, 1'b0, 1'b0, '{default: '0}},
      '{32'hffff_fff0, 6'd28, 1'b1, 1'b0, '{default: '0}}
   };

   initial begin
      stim_row_type row;
      shrr_pkg::rsp_payload_type head;
      int unsigned sent;
      round_cfg = 7'd64;
      iv_cfg = '{64'h6a09e667bb67ae85, 64'h3c6ef372a54ff53a,
                 64'h510e527f9b05688c, 64'h1f83d9ab5be0cd19};
      end_message();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) begin
         row = directed[k];
         hash_word('{message_word: row.word, valid_bits: row.vbits, final_item: row.fin});
         if (row.has_fixed && row.fin) begin
            head = digest_queue[digest_queue.size() - (row.fixed_rsp.status ? 1 : 8)];
            if (head !== row.fixed_rsp) begin
               $error("table row %0d expected %h predicted %h", k, row.fixed_rsp, head);
               error_count++;
            end
         end
         send_word(row.word, row.vbits, row.fin);
      end
      drain();
      table_mode = 1'b0;

      // Register extremes, including round counts above range.
      foreach (iv_cfg[i]) write_csr(shrr_pkg::CsrIv01 + i, '0);
      write_csr(shrr_pkg::CsrRoundCount, 7'd0);
      send_message(1, 0); send_message(17, 0); drain();
      write_csr(shrr_pkg::CsrRoundCount, 7'd127);
      foreach (iv_cfg[i]) write_csr(shrr_pkg::CsrIv01 + i, '1);
      send_message(3, 0); drain();
      write_csr(shrr_pkg::CsrRoundCount, 7'd1);
      send_message(14, 0); send_message(15, 0); drain();

      sent = 0;
      for (int phase = 0; phase < 5; phase++) begin
         rsp_gaps_on = (phase != 2);
         write_csr(shrr_pkg::CsrRoundCount, (phase == 4) ? 7'd64 : $urandom_range(0, 127));
         foreach (iv_cfg[i]) write_csr(shrr_pkg::CsrIv01 + i, {$urandom, $urandom});
         while (sent < (phase + 1) * 90) begin
            automatic int unsigned n = ($urandom_range(0, 9) == 0)
                                       ? $urandom_range(16, 40) : $urandom_range(1, 6);
            send_message(n, $urandom_range(0, 7) == 0);
            sent += n;
         end
         drain();
      end

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Predict at acceptance so the queue follows the order of accepted requests.
   always @(posedge clock) begin
      if (!reset && !table_mode && req_valid && !req_stall) hash_word(req_payload);
   end

endmodule

### files.f
rtl/shrr_pkg.sv
rtl/shrr_datapath.sv
rtl/shrr_control.sv
rtl/sha256_hash_reduced_rounds_unit.sv
tb/tb_sha256_hash_reduced_rounds_unit.sv
